### hw/rtl/first_fit_page_frame_allocator_assert.svh
// Assertion macros shared by the page frame allocator RTL.
// No dependencies; taken in by `include in the files that assert.
`ifndef FIRST_FIT_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFPA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

### hw/rtl/ffpa_pkg.sv
// Shared types and constants of the page frame allocator.
// No dependencies; used by ffpa_ctrl, ffpa_dpath and the top level.
package ffpa_pkg;

	localparam int PAGE_FRAMES = 1024;
	localparam int PAGE_W      = 10;
	localparam int COUNT_W     = 11;
	localparam int ROW_PAGES   = 8;
	localparam int LANE_W      = $clog2(ROW_PAGES);
	localparam int NUM_ROWS    = PAGE_FRAMES / ROW_PAGES;
	localparam int ROW_AW      = $clog2(NUM_ROWS);
	localparam int ENTRY_W     = 3;
	localparam int FREE_BIT    = 0;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [COUNT_W:0]   span_t;
	typedef logic [ROW_AW-1:0]  row_idx_t;
	typedef logic [LANE_W-1:0]  lane_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [ROW_PAGES-1:0][ENTRY_W-1:0] row_t;

	// entry layout: {type[1:0], free}
	localparam entry_t   ENTRY_FREE = 3'b001;
	localparam count_t   PAGES_MAX  = count_t'(PAGE_FRAMES);
	localparam span_t    SPAN_PAGES = span_t'(PAGE_FRAMES);
	localparam row_idx_t LAST_ROW   = row_idx_t'(NUM_ROWS - 1);

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_RESERVE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_ZERO = 2'd1;
	localparam logic [1:0] STS_FAIL = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		page_t      page_index;
		count_t     page_count;
		logic [1:0] page_type;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] status;
		page_t      first_page;
		count_t     free_pages;
		count_t     used_pages;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_MARK,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan_en;
		logic mark_en;
		logic res_load;
		logic res_pass;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic alloc;
		logic scan_hit;
		logic scan_miss;
		logic mark_last;
	} dp_sts_t;

endpackage

### hw/rtl/ffpa_ctrl.sv
// Sequencing state machine of the page frame allocator.
// Depends on ffpa_pkg and first_fit_page_frame_allocator_assert.svh.
`include "first_fit_page_frame_allocator_assert.svh"

module ffpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ffpa_pkg::ctl_cmd_t cmd,
	input  ffpa_pkg::dp_sts_t  sts
);

	ffpa_pkg::state_t state_q, state_d;
	logic pass_q, pass_d;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffpa_pkg::S_IDLE;
			pass_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pass_d    = pass_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ffpa_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ffpa_pkg::S_DECIDE;
				end
			end
			ffpa_pkg::S_DECIDE: begin
				if (sts.bad) begin
					pass_d  = 1'b0;
					state_d = ffpa_pkg::S_DONE;
				end else if (sts.alloc) begin
					state_d = ffpa_pkg::S_SCAN;
				end else begin
					state_d = ffpa_pkg::S_MARK;
				end
			end
			ffpa_pkg::S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_hit) begin
					state_d = ffpa_pkg::S_MARK;
				end else if (sts.scan_miss) begin
					pass_d  = 1'b0;
					state_d = ffpa_pkg::S_DONE;
				end
			end
			ffpa_pkg::S_MARK: begin
				cmd.mark_en = 1'b1;
				if (sts.mark_last) begin
					pass_d  = 1'b1;
					state_d = ffpa_pkg::S_DONE;
				end
			end
			ffpa_pkg::S_DONE: begin
				// hold the result until the output register frees up
				if (!rsp_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					cmd.res_pass = pass_q;
					state_d      = ffpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffpa_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	`FFPA_ASSERT_IMPLIES(a_load_into_free_slot, clk, arst_n, cmd.res_load, !rsp_valid_q || rsp_ready)
	`FFPA_ASSERT_IMPLIES(a_single_action, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.scan_en, cmd.mark_en, cmd.res_load}))
	`FFPA_ASSERT_NEXT(a_result_posted, clk, arst_n, cmd.res_load, rsp_valid_q && state_q == ffpa_pkg::S_IDLE)

endmodule

### hw/rtl/ffpa_dpath.sv
// Datapath of the page frame allocator: page table memory, scan, run marking, counts.
// Depends on ffpa_pkg and first_fit_page_frame_allocator_assert.svh.
`include "first_fit_page_frame_allocator_assert.svh"

module ffpa_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  ffpa_pkg::req_t     req,
	input  ffpa_pkg::ctl_cmd_t cmd,
	output ffpa_pkg::dp_sts_t  sts,
	output ffpa_pkg::rsp_t     rsp
);

	// page table: rows of ROW_PAGES entries, per-row valid marks
	ffpa_pkg::row_t   page_mem_q [ffpa_pkg::NUM_ROWS];
	logic [ffpa_pkg::NUM_ROWS-1:0] row_vld_q;

	ffpa_pkg::req_t   req_q;
	ffpa_pkg::page_t  mark_lo_q, mark_hi_q;
	ffpa_pkg::row_idx_t mrow_q;
	ffpa_pkg::count_t free_q, used_q;
	ffpa_pkg::rsp_t   rsp_q;

	// scan pipeline
	ffpa_pkg::row_idx_t rd_row_q;
	logic               issue_done_q;
	logic               data_ok_s1;
	ffpa_pkg::row_idx_t data_row_s1;
	ffpa_pkg::row_t     rd_data_s1;
	logic               rd_vld_s1;
	ffpa_pkg::count_t   run_q, run_d;
	ffpa_pkg::page_t    start_q, start_d;

	ffpa_pkg::row_t   eff_row;
	logic             hit;
	ffpa_pkg::page_t  hit_lo, hit_hi;

	// request decode
	logic             is_alloc, is_zero;
	ffpa_pkg::span_t  span;
	logic             bad;
	logic [1:0]       err_status;

	// marking
	ffpa_pkg::entry_t fill;
	ffpa_pkg::row_t   wrow;
	logic [ffpa_pkg::ROW_PAGES-1:0] wmask;

	// counts
	ffpa_pkg::span_t  sum_used, sum_free;
	ffpa_pkg::count_t used_up, used_dn, free_up, free_dn;
	ffpa_pkg::count_t used_new, free_new;

	always_comb begin
		is_alloc = req_q.command == ffpa_pkg::CMD_ALLOC;
		is_zero  = req_q.page_count == '0;
		span     = ffpa_pkg::span_t'(req_q.page_index) + ffpa_pkg::span_t'(req_q.page_count);
		bad      = (req_q.command == ffpa_pkg::CMD_UNUSED) || is_zero
			|| (is_alloc ? (req_q.page_count > ffpa_pkg::PAGES_MAX)
			             : (span > ffpa_pkg::SPAN_PAGES));
		err_status = (req_q.command != ffpa_pkg::CMD_UNUSED && is_zero)
			? ffpa_pkg::STS_ZERO : ffpa_pkg::STS_FAIL;
	end

	// one row per cycle; the run length carries across rows
	always_comb begin
		eff_row = rd_vld_s1 ? rd_data_s1 : {ffpa_pkg::ROW_PAGES{ffpa_pkg::ENTRY_FREE}};
		run_d   = run_q;
		start_d = start_q;
		hit     = 1'b0;
		hit_lo  = start_q;
		hit_hi  = '0;
		for (int j = 0; j < ffpa_pkg::ROW_PAGES; j++) begin
			if (eff_row[j][ffpa_pkg::FREE_BIT]) begin
				if (run_d == '0) begin
					start_d = {data_row_s1, ffpa_pkg::lane_t'(j)};
				end
				run_d = run_d + 1'b1;
				if (!hit && run_d == req_q.page_count) begin
					hit    = 1'b1;
					hit_lo = start_d;
					hit_hi = {data_row_s1, ffpa_pkg::lane_t'(j)};
				end
			end else begin
				run_d = '0;
			end
		end
	end

	always_comb begin
		fill = (req_q.command == ffpa_pkg::CMD_FREE) ? ffpa_pkg::ENTRY_FREE
			: {req_q.page_type, 1'b0};
		for (int j = 0; j < ffpa_pkg::ROW_PAGES; j++) begin
			// an untouched row is written whole so its other pages read as free
			if ({mrow_q, ffpa_pkg::lane_t'(j)} >= mark_lo_q
				&& {mrow_q, ffpa_pkg::lane_t'(j)} <= mark_hi_q) begin
				wmask[j] = 1'b1;
				wrow[j]  = fill;
			end else begin
				wmask[j] = !row_vld_q[mrow_q];
				wrow[j]  = ffpa_pkg::ENTRY_FREE;
			end
		end
	end

	// saturating count updates
	always_comb begin
		sum_used = ffpa_pkg::span_t'(used_q) + ffpa_pkg::span_t'(req_q.page_count);
		sum_free = ffpa_pkg::span_t'(free_q) + ffpa_pkg::span_t'(req_q.page_count);
		used_up  = (sum_used > ffpa_pkg::SPAN_PAGES) ? ffpa_pkg::PAGES_MAX
			: ffpa_pkg::count_t'(sum_used);
		free_up  = (sum_free > ffpa_pkg::SPAN_PAGES) ? ffpa_pkg::PAGES_MAX
			: ffpa_pkg::count_t'(sum_free);
		used_dn  = (req_q.page_count > used_q) ? '0 : used_q - req_q.page_count;
		free_dn  = (req_q.page_count > free_q) ? '0 : free_q - req_q.page_count;
		if (req_q.command == ffpa_pkg::CMD_FREE) begin
			used_new = used_dn;
			free_new = free_up;
		end else begin
			used_new = used_up;
			free_new = free_dn;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			free_q       <= ffpa_pkg::PAGES_MAX;
			used_q       <= '0;
			rd_row_q     <= '0;
			issue_done_q <= 1'b0;
			data_ok_s1   <= 1'b0;
		end else begin
			if (cmd.mark_en) begin
				row_vld_q[mrow_q] <= 1'b1;
			end
			if (cmd.res_load && cmd.res_pass) begin
				free_q <= free_new;
				used_q <= used_new;
			end
			if (cmd.load) begin
				rd_row_q     <= '0;
				issue_done_q <= 1'b0;
				data_ok_s1   <= 1'b0;
			end else if (cmd.scan_en) begin
				data_ok_s1 <= !issue_done_q;
				if (!issue_done_q) begin
					rd_row_q <= rd_row_q + 1'b1;
					if (rd_row_q == ffpa_pkg::LAST_ROW) begin
						issue_done_q <= 1'b1;
					end
				end
			end else begin
				data_ok_s1 <= 1'b0;
			end
		end
	end

	// memory and payload
	always_ff @(posedge clk) begin
		rd_data_s1  <= page_mem_q[rd_row_q];
		rd_vld_s1   <= row_vld_q[rd_row_q];
		data_row_s1 <= rd_row_q;
		if (cmd.mark_en) begin
			for (int j = 0; j < ffpa_pkg::ROW_PAGES; j++) begin
				if (wmask[j]) begin
					page_mem_q[mrow_q][j] <= wrow[j];
				end
			end
		end

		if (cmd.load) begin
			req_q     <= req;
			mark_lo_q <= req.page_index;
			mark_hi_q <= ffpa_pkg::page_t'(ffpa_pkg::span_t'(req.page_index)
				+ ffpa_pkg::span_t'(req.page_count) - 1'b1);
			mrow_q    <= req.page_index[ffpa_pkg::PAGE_W-1:ffpa_pkg::LANE_W];
			run_q     <= '0;
			start_q   <= '0;
		end else if (cmd.scan_en && data_ok_s1) begin
			run_q   <= run_d;
			start_q <= start_d;
			if (hit) begin
				mark_lo_q <= hit_lo;
				mark_hi_q <= hit_hi;
				mrow_q    <= hit_lo[ffpa_pkg::PAGE_W-1:ffpa_pkg::LANE_W];
			end
		end else if (cmd.mark_en) begin
			mrow_q <= mrow_q + 1'b1;
		end

		if (cmd.res_load) begin
			rsp_q.ok         <= cmd.res_pass;
			rsp_q.status     <= cmd.res_pass ? ffpa_pkg::STS_OK : err_status;
			rsp_q.first_page <= (cmd.res_pass && is_alloc) ? mark_lo_q : '0;
			rsp_q.free_pages <= cmd.res_pass ? free_new : free_q;
			rsp_q.used_pages <= cmd.res_pass ? used_new : used_q;
		end
	end

	assign sts.bad       = bad;
	assign sts.alloc     = is_alloc;
	assign sts.scan_hit  = data_ok_s1 && hit;
	assign sts.scan_miss = data_ok_s1 && !hit && data_row_s1 == ffpa_pkg::LAST_ROW;
	assign sts.mark_last = mrow_q == mark_hi_q[ffpa_pkg::PAGE_W-1:ffpa_pkg::LANE_W];
	assign rsp           = rsp_q;

	`FFPA_ASSERT_IMPLIES(a_counts_bounded, clk, arst_n, 1'b1, free_q <= ffpa_pkg::PAGES_MAX && used_q <= ffpa_pkg::PAGES_MAX)
	`FFPA_ASSERT_NEXT(a_hit_run_length, clk, arst_n, sts.scan_hit, ffpa_pkg::count_t'(mark_hi_q - mark_lo_q) + 1'b1 == req_q.page_count)
	`FFPA_ASSERT_IMPLIES(a_mark_within_run, clk, arst_n, cmd.mark_en, mrow_q <= mark_hi_q[ffpa_pkg::PAGE_W-1:ffpa_pkg::LANE_W])

endmodule

### hw/rtl/first_fit_page_frame_allocator.sv
// First-fit page frame allocator. A request carries allocate, free or reserve for a run of
// page_count pages; each request gives one response with status and the free and used counts.
// The page table lives in a memory of 128 rows of 8 pages with one valid mark per row, so
// the block is ready right out of reset with every page free and no clearing pass.
// Errors (zero count, command 3, run past the end, count above 1024) go straight to the
// response; free and reserve mark the R rows of 8 pages that the run touches; allocate
// first scans rows 0 to H, H being the row of the run's last page, then marks the run. The
// scan reads one row per cycle through the single registered read port, and marking writes
// one row per cycle. A failed allocate scans all rows.
// The next request is taken while an earlier response still waits in the output register.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_dpath.

module first_fit_page_frame_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffpa_pkg::rsp_t rsp
);

	ffpa_pkg::ctl_cmd_t cmd;
	ffpa_pkg::dp_sts_t  sts;

	// sequencing: accept, decode, scan, mark, post response
	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// page table, first-fit scan, run marking, saturating counts, response register
	ffpa_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
